// File: rtl/ptlru_pkg.sv
// ----------------------------------------------------------------------------
// ptlru_pkg
// shared widths and register map of the page translation block
// ----------------------------------------------------------------------------
package ptlru_pkg;

  localparam int ADDR_W      = 20;
  localparam int PID_W       = 2;
  localparam int FRAME_OUT_W = 4;
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;

  localparam logic [1:0] REG_OFFSET_BITS    = 2'd0;
  localparam logic [1:0] REG_PHYS_ADDR_BITS = 2'd1;
  localparam logic [1:0] REG_VIRT_ADDR_BITS = 2'd2;
  localparam logic [1:0] REG_PROCESS_COUNT  = 2'd3;

  localparam logic [4:0] OFFSET_BITS_RST    = 5'd12;
  localparam logic [4:0] PHYS_ADDR_BITS_RST = 5'd16;
  localparam logic [4:0] VIRT_ADDR_BITS_RST = 5'd20;
  localparam logic [2:0] PROCESS_COUNT_RST  = 3'd4;

endpackage

// File: rtl/page_translate_lru_replace_top.sv
// ----------------------------------------------------------------------------
// page_translate_lru_replace_top
// per-process page table lookup with least-recently-used frame replacement
// ----------------------------------------------------------------------------
// One transaction at a time. An access error goes from acceptance to the
// result register through S_FINISH, and a hit through S_CHECK and S_FINISH. A
// miss walks the frame table one entry per cycle through a single stamp
// comparator, at most MAX_FRAMES entries, then goes through S_MAP when a free
// frame is found, or S_EVICT and S_MAP when a frame is evicted, to S_FINISH.
// The result register must be free or draining before a result is loaded, and
// in_ready returns at the edge that loads it. After reset the page table
// memory is cleared one entry per cycle; until that is done no transaction is
// accepted, but configuration writes are taken.
// ----------------------------------------------------------------------------
module page_translate_lru_replace_top #(
  parameter int MAX_PROCS   = 4,
  parameter int MAX_VPAGES  = 256,
  parameter int MAX_FRAMES  = 16,
  parameter int STAMP_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ptlru_pkg::PID_W-1:0]      proc_id,
  input  logic [ptlru_pkg::ADDR_W-1:0]     virt_addr,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ptlru_pkg::ADDR_W-1:0]     virtual_page,
  output logic [ptlru_pkg::FRAME_OUT_W-1:0] frame_number,
  output logic [ptlru_pkg::ADDR_W-1:0]     phys_addr,
  output logic                             fault,
  output logic                             access_error,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ptlru_pkg::APB_AW-1:0]     paddr,
  input  logic [ptlru_pkg::APB_DW-1:0]     pwdata,
  output logic [ptlru_pkg::APB_DW-1:0]     prdata,
  output logic                             pready
);
  import ptlru_pkg::*;

  localparam int PIDW     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int VPW      = $clog2(MAX_VPAGES);
  localparam int FW       = $clog2(MAX_FRAMES);
  localparam int PTW      = PIDW + VPW;
  localparam int PT_DEPTH = 1 << PTW;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SCAN, S_EVICT, S_MAP, S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [4:0] offset_bits, phys_addr_bits, virt_addr_bits;
  logic [2:0] process_count;

  // page table memory
  logic [FW:0]    page_mem [PT_DEPTH];
  logic [FW:0]    pt_rdata;
  logic [PTW-1:0] pt_raddr, pt_waddr;
  logic [FW:0]    pt_wdata;
  logic           pt_we;

  // frame table
  logic                   frame_in_use [MAX_FRAMES];
  logic [PIDW-1:0]        frame_pid    [MAX_FRAMES];
  logic [VPW-1:0]         frame_page   [MAX_FRAMES];
  logic [STAMP_WIDTH-1:0] frame_stamp  [MAX_FRAMES];

  logic [STAMP_WIDTH-1:0] use_clock, vstamp;
  logic [PTW-1:0]         clr_cnt;
  logic [FW-1:0]          scan_i, victim, frame, frame_sel, hit_idx;
  logic [PIDW-1:0]        pid_q;
  logic [ADDR_W-1:0]      va_q, vpage_q;
  logic                   err_q;
  logic                   fault_q;

  logic [ADDR_W-1:0] vpage_in, off_mask, pa_calc;
  logic [4:0]        vdiff, fdiff;
  logic              page_ok, pid_ok;
  logic [FW:0]       scan_nxt;
  logic              scan_last, take;
  logic              sel_in_use;
  logic [PIDW-1:0]   sel_pid;
  logic [VPW-1:0]    sel_page;
  logic [STAMP_WIDTH-1:0] sel_stamp;
  logic              cfg_wr;

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_OFFSET_BITS:    prdata = APB_DW'(offset_bits);
      REG_PHYS_ADDR_BITS: prdata = APB_DW'(phys_addr_bits);
      REG_VIRT_ADDR_BITS: prdata = APB_DW'(virt_addr_bits);
      REG_PROCESS_COUNT:  prdata = APB_DW'(process_count);
      default:            prdata = '0;
    endcase
  end

  // range checks on the incoming access
  assign vpage_in = virt_addr >> offset_bits;
  assign vdiff    = (virt_addr_bits > offset_bits) ? virt_addr_bits - offset_bits : 5'd0;
  assign fdiff    = (phys_addr_bits > offset_bits) ? phys_addr_bits - offset_bits : 5'd0;
  assign page_ok  = ((vpage_in >> vdiff) == '0) && (vpage_in < ADDR_W'(MAX_VPAGES));
  assign pid_ok   = (3'(proc_id) < process_count) && (5'(proc_id) < 5'(MAX_PROCS));

  assign pt_raddr = {PIDW'(proc_id), vpage_in[VPW-1:0]};

  // frame table read port
  assign frame_sel  = (state == S_SCAN) ? scan_i : frame;
  assign sel_in_use = frame_in_use[frame_sel];
  assign sel_pid    = frame_pid[frame_sel];
  assign sel_page   = frame_page[frame_sel];
  assign sel_stamp  = frame_stamp[frame_sel];
  assign hit_idx    = pt_rdata[FW-1:0];

  assign scan_nxt  = {1'b0, scan_i} + (FW+1)'(1);
  assign scan_last = (scan_i == FW'(MAX_FRAMES - 1)) || ((scan_nxt >> fdiff) != '0);
  assign take      = (scan_i == '0) || ((sel_pid == pid_q) && (sel_stamp < vstamp));

  assign off_mask = ~({ADDR_W{1'b1}} << offset_bits);
  assign pa_calc  = (ADDR_W'(frame) << offset_bits) | (va_q & off_mask);

  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = clr_cnt;
    pt_wdata = '0;
    case (state)
      S_CLEAR: begin
        pt_we = 1'b1;
      end
      S_EVICT: begin
        pt_we    = 1'b1;
        pt_waddr = {sel_pid, sel_page};
      end
      S_MAP: begin
        pt_we    = 1'b1;
        pt_waddr = {pid_q, vpage_q[VPW-1:0]};
        pt_wdata = {1'b1, frame};
      end
      default: pt_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      page_mem[pt_waddr] <= pt_wdata;
    end
    pt_rdata <= page_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_CHECK && pt_rdata[FW]) begin
      frame_stamp[hit_idx] <= use_clock;
    end
    if (state == S_MAP) begin
      frame_pid[frame]   <= pid_q;
      frame_page[frame]  <= vpage_q[VPW-1:0];
      frame_stamp[frame] <= use_clock;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_cnt        <= '0;
      use_clock      <= '0;
      out_valid      <= 1'b0;
      offset_bits    <= OFFSET_BITS_RST;
      phys_addr_bits <= PHYS_ADDR_BITS_RST;
      virt_addr_bits <= VIRT_ADDR_BITS_RST;
      process_count  <= PROCESS_COUNT_RST;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        frame_in_use[i] <= 1'b0;
      end
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_OFFSET_BITS:    offset_bits    <= pwdata[4:0];
          REG_PHYS_ADDR_BITS: phys_addr_bits <= pwdata[4:0];
          REG_VIRT_ADDR_BITS: virt_addr_bits <= pwdata[4:0];
          REG_PROCESS_COUNT:  process_count  <= pwdata[2:0];
          default:            process_count  <= process_count;
        endcase
      end
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + PTW'(1);
          if (clr_cnt == PTW'(PT_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            pid_q   <= PIDW'(proc_id);
            va_q    <= virt_addr;
            vpage_q <= vpage_in;
            err_q   <= !(page_ok && pid_ok);
            state   <= (page_ok && pid_ok) ? S_CHECK : S_FINISH;
          end
        end
        S_CHECK: begin
          if (pt_rdata[FW]) begin
            frame     <= hit_idx;
            use_clock <= use_clock + STAMP_WIDTH'(1);
            fault_q   <= 1'b0;
            state     <= S_FINISH;
          end else begin
            scan_i <= '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!sel_in_use) begin
            frame <= scan_i;
            state <= S_MAP;
          end else begin
            if (take) begin
              victim <= scan_i;
              vstamp <= sel_stamp;
            end
            if (scan_last) begin
              frame <= take ? scan_i : victim;
              state <= S_EVICT;
            end else begin
              scan_i <= scan_nxt[FW-1:0];
            end
          end
        end
        S_EVICT: begin
          state <= S_MAP;
        end
        S_MAP: begin
          frame_in_use[frame] <= 1'b1;
          use_clock           <= use_clock + STAMP_WIDTH'(1);
          fault_q             <= 1'b1;
          state               <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            virtual_page <= vpage_q;
            access_error <= err_q;
            if (err_q) begin
              frame_number <= '0;
              phys_addr    <= '0;
              fault        <= 1'b0;
            end else begin
              frame_number <= FRAME_OUT_W'(frame);
              phys_addr    <= pa_calc;
              fault        <= fault_q;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/ptlru_checker.sv
// ----------------------------------------------------------------------------
// ptlru_checker
// port-level checks for the page translation block
// ----------------------------------------------------------------------------
module ptlru_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [ptlru_pkg::ADDR_W-1:0]     virtual_page,
  input logic [ptlru_pkg::FRAME_OUT_W-1:0] frame_number,
  input logic [ptlru_pkg::ADDR_W-1:0]     phys_addr,
  input logic                             fault,
  input logic                             access_error
);
  import ptlru_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(virtual_page) &&
      $stable(frame_number) && $stable(phys_addr) &&
      $stable(fault) && $stable(access_error))
    else $error("result changed while stalled");

  // rejected access carries no translation
  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && access_error |-> !fault && frame_number == '0 &&
      phys_addr == '0)
    else $error("access error with translation fields set");

  // one transaction in flight at a time
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted transaction");

endmodule

bind page_translate_lru_replace_top ptlru_checker u_ptlru_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the page translation block with least-recently-used frame
// replacement. Accesses go through a valid/ready channel. A predictor keeps
// its own page tables, frame table and use clock. Each result is compared
// field by field with the oldest expected translation. Directed tests cover
// the register reset values, access errors, eviction, narrow and wide widths,
// reconfiguration and one long output stall. Random phases then run under
// varied settings, with random gaps on both sides in all but one phase.
// ----------------------------------------------------------------------------
module tb;
  import ptlru_pkg::*;

  localparam int WATCHDOG_LIMIT = 8000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLD_CYCLES    = 200;
  localparam int NUM_PROCS      = 4;
  localparam int NUM_VPAGES     = 256;
  localparam int NUM_FRAMES     = 16;

  typedef struct packed {
    logic [ADDR_W-1:0]      vpage;
    logic [FRAME_OUT_W-1:0] frame;
    logic [ADDR_W-1:0]      paddr;
    logic                   fault;
    logic                   err;
  } xlate_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [PID_W-1:0]       proc_id;
  logic [ADDR_W-1:0]      virt_addr;
  logic                   out_valid;
  logic                   out_ready;
  logic [ADDR_W-1:0]      virtual_page;
  logic [FRAME_OUT_W-1:0] frame_number;
  logic [ADDR_W-1:0]      phys_addr;
  logic                   fault;
  logic                   access_error;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_AW-1:0]      paddr;
  logic [APB_DW-1:0]      pwdata;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  // predictor state
  bit          pt_valid [NUM_PROCS][NUM_VPAGES];
  logic [3:0]  pt_frame [NUM_PROCS][NUM_VPAGES];
  bit          fr_used  [NUM_FRAMES];
  logic [1:0]  fr_pid   [NUM_FRAMES];
  int          fr_page  [NUM_FRAMES];
  logic [31:0] fr_stamp [NUM_FRAMES];
  logic [31:0] lru_clock;
  logic [4:0]  cfg_off;
  logic [4:0]  cfg_phys;
  logic [4:0]  cfg_virt;
  logic [2:0]  cfg_procs;

  xlate_t pending_xlates[$];
  xlate_t want;
  int     mismatch_count;
  int     cfg_mismatches;
  int     idle_cycles;
  int     hold_req;
  bit     no_gaps;

  page_translate_lru_replace_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .proc_id      (proc_id),
    .virt_addr    (virt_addr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .virtual_page (virtual_page),
    .frame_number (frame_number),
    .phys_addr    (phys_addr),
    .fault        (fault),
    .access_error (access_error),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int span_count(int hi, int lo, int cap);
    int n;
    if (hi <= lo) return 1;
    n = 1 << (hi - lo);
    return (n > cap) ? cap : n;
  endfunction

  function automatic xlate_t predict_translation(logic [1:0] pid, logic [ADDR_W-1:0] va);
    xlate_t r;
    int vp;
    int np;
    int nf;
    int fr;
    int victim;
    bit found;
    logic [ADDR_W-1:0] offmask;
    vp = int'(va >> cfg_off);
    np = span_count(int'(cfg_virt), int'(cfg_off), NUM_VPAGES);
    nf = span_count(int'(cfg_phys), int'(cfg_off), NUM_FRAMES);
    r = '0;
    r.vpage = ADDR_W'(vp);
    r.err = 1'b1;
    if (int'(pid) >= int'(cfg_procs) || vp >= np) return r;
    found = 0;
    victim = 0;
    fr = 0;
    if (pt_valid[pid][vp]) begin
      fr = int'(pt_frame[pid][vp]);
      fr_stamp[fr] = lru_clock;
      lru_clock = lru_clock + 32'd1;
    end else begin
      for (int i = 0; i < nf && !found; i++) begin
        if (!fr_used[i]) begin
          fr = i;
          found = 1;
        end else if (i == 0 || (fr_pid[i] == pid && fr_stamp[i] < fr_stamp[victim])) begin
          victim = i;
        end
      end
      if (!found) begin
        fr = victim;
        pt_valid[fr_pid[victim]][fr_page[victim]] = 0;
      end
      fr_used[fr] = 1;
      fr_pid[fr] = pid;
      fr_page[fr] = vp;
      fr_stamp[fr] = lru_clock;
      lru_clock = lru_clock + 32'd1;
      pt_valid[pid][vp] = 1;
      pt_frame[pid][vp] = 4'(fr);
      r.fault = 1'b1;
    end
    offmask = (20'h1 << cfg_off) - 20'h1;
    r.frame = FRAME_OUT_W'(fr);
    r.paddr = ADDR_W'(fr << cfg_off) | (va & offmask);
    r.err = 1'b0;
    return r;
  endfunction

  // one access transaction, called and returning at a falling edge
  task automatic send_access(input logic [1:0] pid, input logic [ADDR_W-1:0] va);
    int gap;
    gap = no_gaps ? 0 : int'($urandom_range(0, 15));
    if (gap > 0) begin
      in_valid = 1'b0;
      proc_id = PID_W'($urandom);
      virt_addr = ADDR_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    proc_id = pid;
    virt_addr = va;
    do @(posedge clk); while (!in_ready);
    pending_xlates.push_back(predict_translation(pid, va));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_xlates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_read_check(input logic [1:0] idx, input logic [APB_DW-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata !== value) begin
      $error("prdata reg %0d: expected %0h, got %0h", idx, value, prdata);
      cfg_mismatches++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [APB_DW-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_OFFSET_BITS:    cfg_off = value[4:0];
      REG_PHYS_ADDR_BITS: cfg_phys = value[4:0];
      REG_VIRT_ADDR_BITS: cfg_virt = value[4:0];
      REG_PROCESS_COUNT:  cfg_procs = value[2:0];
      default: ;
    endcase
    apb_read_check(idx, value);
  endtask

  task automatic set_config(input int off, input int phys, input int virt, input int procs);
    wait_idle();
    apb_write(REG_OFFSET_BITS, off);
    apb_write(REG_PHYS_ADDR_BITS, phys);
    apb_write(REG_VIRT_ADDR_BITS, virt);
    apb_write(REG_PROCESS_COUNT, procs);
  endtask

  task automatic test_register_reset();
    apb_read_check(REG_OFFSET_BITS, {27'd0, OFFSET_BITS_RST});
    apb_read_check(REG_PHYS_ADDR_BITS, {27'd0, PHYS_ADDR_BITS_RST});
    apb_read_check(REG_VIRT_ADDR_BITS, {27'd0, VIRT_ADDR_BITS_RST});
    apb_read_check(REG_PROCESS_COUNT, {29'd0, PROCESS_COUNT_RST});
  endtask

  task automatic test_default_translation();
    send_access(2'd0, 20'h00000);
    send_access(2'd0, 20'h00FFF);
    send_access(2'd3, 20'hFFFFF);
    send_access(2'd3, 20'hFF800);
    send_access(2'd2, 20'h5A5A5);
    send_access(2'd1, 20'hA5A5A);
  endtask

  task automatic test_access_errors();
    set_config(12, 16, 14, 1);
    send_access(2'd1, 20'h00000);
    send_access(2'd3, 20'h03FFF);
    send_access(2'd0, 20'h03FFF);
    send_access(2'd0, 20'h04000);
    send_access(2'd0, 20'hFFFFF);
  endtask

  // two frames, so once both are taken every miss evicts
  task automatic test_lru_eviction();
    set_config(12, 13, 16, 4);
    send_access(2'd0, 20'h01000);
    send_access(2'd0, 20'h00000);
    send_access(2'd3, 20'h00000);
    send_access(2'd3, 20'h0F123);
    send_access(2'd0, 20'h00ABC);
    send_access(2'd3, 20'h00001);
  endtask

  task automatic test_narrow_widths();
    set_config(16, 1, 1, 4);
    send_access(2'd2, 20'h0FFFF);
    send_access(2'd2, 20'h10000);
    send_access(2'd1, 20'h0ABCD);
  endtask

  task automatic test_wide_widths();
    set_config(1, 20, 20, 4);
    send_access(2'd0, 20'h001FF);
    send_access(2'd0, 20'h00200);
    send_access(2'd1, 20'hFFFFF);
  endtask

  // mappings to frames past the new frame count must still hit
  task automatic test_reconfig_keeps_mappings();
    send_access(2'd2, 20'h00014);
    send_access(2'd2, 20'h00017);
    send_access(2'd2, 20'h0001A);
    set_config(1, 2, 20, 4);
    send_access(2'd2, 20'h00015);
    send_access(2'd2, 20'h0001A);
    send_access(2'd2, 20'h00030);
  endtask

  task automatic send_random_access();
    int np;
    int nf;
    int pool;
    int vp;
    int pick;
    logic [1:0] pid;
    logic [ADDR_W-1:0] offmask;
    logic [ADDR_W-1:0] va;
    np = span_count(int'(cfg_virt), int'(cfg_off), NUM_VPAGES);
    nf = span_count(int'(cfg_phys), int'(cfg_off), NUM_FRAMES);
    pool = (nf + 3 > np) ? np : nf + 3;
    offmask = (20'h1 << cfg_off) - 20'h1;
    pid = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) :
                                        2'($urandom_range(0, int'(cfg_procs) - 1));
    pick = int'($urandom_range(0, 19));
    if (pick == 0) begin
      va = ADDR_W'($urandom);
    end else begin
      vp = (pick == 1) ? np : int'($urandom_range(0, pool - 1));
      va = ADDR_W'(vp << cfg_off) | (ADDR_W'($urandom) & offmask);
    end
    send_access(pid, va);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(1, 20, 20, 4);
        1: set_config(16, 20, 20, 1);
        default: set_config($urandom_range(1, 16), $urandom_range(1, 20),
                            $urandom_range(1, 20), $urandom_range(1, 4));
      endcase
      no_gaps = (ph == 2);
      repeat (70) send_random_access();
      no_gaps = 0;
    end
  endtask

  // receiver stalls long enough for the block to fill and drop in_ready
  task automatic test_output_backpressure();
    set_config(12, 14, 16, 4);
    @(posedge clk);
    hold_req++;
    @(negedge clk);
    no_gaps = 1;
    repeat (20) send_random_access();
    no_gaps = 0;
  endtask

  // receiver
  initial begin
    int  hold_seen;
    int  hold_left;
    int  wait_left;
    bit  taken;
    hold_seen = 0;
    hold_left = 0;
    wait_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      taken = out_valid && out_ready;
      @(negedge clk);
      if (taken) begin
        wait_left = no_gaps ? 0 : int'($urandom_range(0, 15));
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (wait_left > 0) begin
        out_ready = 1'b0;
        wait_left--;
      end else begin
        out_ready = !rst;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_xlates.size() == 0) begin
        $error("result transaction with no access pending");
        mismatch_count++;
      end else begin
        want = pending_xlates.pop_front();
        if (virtual_page !== want.vpage) begin
          $error("virtual_page: expected %0h, got %0h", want.vpage, virtual_page);
          mismatch_count++;
        end
        if (frame_number !== want.frame) begin
          $error("frame_number: expected %0h, got %0h", want.frame, frame_number);
          mismatch_count++;
        end
        if (phys_addr !== want.paddr) begin
          $error("phys_addr: expected %0h, got %0h", want.paddr, phys_addr);
          mismatch_count++;
        end
        if (fault !== want.fault) begin
          $error("fault: expected %0b, got %0b", want.fault, fault);
          mismatch_count++;
        end
        if (access_error !== want.err) begin
          $error("access_error: expected %0b, got %0b", want.err, access_error);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    proc_id = '0;
    virt_addr = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_mismatches = 0;
    hold_req = 0;
    no_gaps = 0;
    foreach (pt_valid[p, v]) begin
      pt_valid[p][v] = 0;
      pt_frame[p][v] = '0;
    end
    foreach (fr_used[f]) begin
      fr_used[f] = 0;
      fr_pid[f] = '0;
      fr_page[f] = 0;
      fr_stamp[f] = '0;
    end
    lru_clock = '0;
    cfg_off = OFFSET_BITS_RST;
    cfg_phys = PHYS_ADDR_BITS_RST;
    cfg_virt = VIRT_ADDR_BITS_RST;
    cfg_procs = PROCESS_COUNT_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_register_reset();
    test_default_translation();
    test_access_errors();
    test_lru_eviction();
    test_narrow_widths();
    test_wide_widths();
    test_reconfig_keeps_mappings();
    test_output_backpressure();
    test_random_phases();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && cfg_mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
